[rtl/ventilation_stage_sequencer_core_assert.svh]
// Assertion macros shared by the ventilation stage sequencer modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef VENTILATION_STAGE_SEQUENCER_CORE_ASSERT_SVH
`define VENTILATION_STAGE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VSS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/vss_pkg.sv]
// Package for the ventilation stage sequencer: item types, register codes,
// reset values and the heater duty table. Depends on nothing.
package vss_pkg;

   localparam int HEATER_LEVELS = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam int TICK_W  = 15;
   localparam int TIMER_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [TICK_W-1:0] VALVE_OPEN_RESET   = 15'd300;
   localparam logic [TICK_W-1:0] VALVE_CLOSE_RESET  = 15'd300;
   localparam logic [TICK_W-1:0] VALVE_GUARD_RESET  = 15'd50;
   localparam logic [TICK_W-1:0] MOTOR_START_RESET  = 15'd200;
   localparam logic [TICK_W-1:0] HEATER_COOL_RESET  = 15'd4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_VALVE_OPEN  = 3'd0,
      CFG_VALVE_CLOSE = 3'd1,
      CFG_VALVE_GUARD = 3'd2,
      CFG_MOTOR_START = 3'd3,
      CFG_HEATER_COOL = 3'd4
   } cfg_index_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_CMD  = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [TICK_W-1:0]    data;
   } csr_wr_type;

   typedef struct packed {
      item_kind_type kind;
      logic [3:0]    target_stage;
      logic [2:0]    heater_level;
      logic          heater_mode;
   } queue_item_type;

   typedef struct packed {
      logic [1:0] current_stage;
      logic [3:0] target_stage;
      logic [2:0] heater_level_now;
      logic [2:0] heater_level_goal;
      logic       heater_mode_now;
      logic [7:0] remaining_time_code;
      logic       pwm_enable;
      logic [7:0] pwm_duty;
   } rsp_item_type;

   // Heater PWM compare values; indexes past the last given level repeat it.
   function automatic logic [7:0] duty_of(input logic [2:0] level);
      logic [7:0] duty;
      case (level)
         3'd0: duty = 8'd0;
         3'd1: duty = 8'd24;
         3'd2: duty = 8'd31;
         3'd3: duty = 8'd40;
         3'd4: duty = 8'd51;
         default: duty = 8'd92;
      endcase
      return duty;
   endfunction

endpackage

[rtl/vss_if.sv]
// Channel interfaces for the ventilation stage sequencer: request and status.
// Depends on nothing.
interface vss_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [3:0] cmd_target_stage;
   logic [2:0] cmd_heater_level;
   logic       cmd_heater_mode;

   modport source (output valid, req_type, cmd_target_stage, cmd_heater_level,
                   cmd_heater_mode, input ready);
   modport sink (input valid, req_type, cmd_target_stage, cmd_heater_level,
                 cmd_heater_mode, output ready);
endinterface

interface vss_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] current_stage;
   logic [3:0] target_stage;
   logic [2:0] heater_level_now;
   logic [2:0] heater_level_goal;
   logic       heater_mode_now;
   logic [7:0] remaining_time_code;
   logic       pwm_enable;
   logic [7:0] pwm_duty;

   modport source (output valid, current_stage, target_stage, heater_level_now,
                   heater_level_goal, heater_mode_now, remaining_time_code,
                   pwm_enable, pwm_duty, input ready);
   modport sink (input valid, current_stage, target_stage, heater_level_now,
                 heater_level_goal, heater_mode_now, remaining_time_code,
                 pwm_enable, pwm_duty, output ready);
endinterface

[rtl/ventilation_stage_sequencer_core.sv]
// Top level of the ventilation stage sequencer: front queue and back executor.
// Depends on vss_pkg, vss_if, vss_front and vss_back.
//
//   channel   direction  beat contents
//   req_chan  in         tick or command: type, target stage, heater level, mode
//   rsp_chan  out        status: stages, heater levels and mode, time code, PWM
//   csr_*     in         register write: enable, index, 15-bit value
//
// A new beat is accepted each cycle while the output register drains. A request
// is held in the front queue and then goes through the back end's state update
// and output register before its status appears. A stalled status output holds
// the back end; the front queue keeps accepting until its two entries are full.
// Reset is synchronous.
module ventilation_stage_sequencer_core #(
   parameter int HEATER_LEVELS = vss_pkg::HEATER_LEVELS,
   parameter int QUEUE_DEPTH   = vss_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   vss_req_if.sink                          req_chan,
   vss_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [vss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vss_pkg::TICK_W-1:0]       csr_wdata
);

   vss_pkg::csr_wr_type     csr;
   vss_pkg::queue_item_type q_item;
   logic                    q_valid;
   logic                    q_pop;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   vss_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop)
   );

   vss_back #(
      .HEATER_LEVELS(HEATER_LEVELS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop),
      .rsp    (rsp_chan)
   );

endmodule

[rtl/vss_front.sv]
// Front end of the sequencer: accepts request beats, classifies them and
// queues them for the back end. Depends on vss_pkg, vss_if and the assert header.
`include "ventilation_stage_sequencer_core_assert.svh"

module vss_front #(
   parameter int QUEUE_DEPTH = vss_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   vss_req_if.sink                 req,
   output logic                    q_valid,
   output vss_pkg::queue_item_type q_item,
   input  logic                    q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   vss_pkg::queue_item_type slot_ff [QUEUE_DEPTH];
   vss_pkg::queue_item_type new_item;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req.ready = (count_ff != CNT_FULL);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind         = req.req_type ? vss_pkg::KIND_CMD : vss_pkg::KIND_TICK;
      new_item.target_stage = req.cmd_target_stage;
      new_item.heater_level = req.cmd_heater_level;
      new_item.heater_mode  = req.cmd_heater_mode;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   `VSS_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL, "queue overfilled")
   `VSS_ASSERT_HOLDS(a_pop_nonempty, clock, reset, q_pop, count_ff != '0, "pop from empty queue")
   `VSS_ASSERT_NEXT(a_push_counts, clock, reset, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

[rtl/vss_back.sv]
// Back end of the sequencer: holds the registers and stage state, executes
// queued beats and drives the status output register. Depends on vss_pkg,
// vss_if and the assert header.
`include "ventilation_stage_sequencer_core_assert.svh"

module vss_back #(
   parameter int HEATER_LEVELS = vss_pkg::HEATER_LEVELS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vss_pkg::csr_wr_type     csr,
   input  logic                    q_valid,
   input  vss_pkg::queue_item_type q_item,
   output logic                    q_pop,
   vss_rsp_if.source               rsp
);

   localparam logic [2:0] LEVEL_MAX = 3'(HEATER_LEVELS - 1);

   typedef enum logic [1:0] {
      S1 = 2'd0,
      S2 = 2'd1,
      S3 = 2'd2,
      S4 = 2'd3
   } stage_type;

   logic [vss_pkg::TICK_W-1:0] valve_open_ff, valve_close_ff, valve_guard_ff;
   logic [vss_pkg::TICK_W-1:0] motor_start_ff, heater_cool_ff;

   stage_type  stage_ff, stage_in;
   logic [3:0] goal_ff, goal_in;
   logic [3:0] goal_seen_ff, goal_seen_in;
   logic [vss_pkg::TIMER_W-1:0] up_ff, up_in;
   logic [vss_pkg::TIMER_W-1:0] down_ff, down_in;
   logic [2:0] applied_ff, applied_in;
   logic [2:0] requested_ff, requested_in;
   logic       auto_ff, auto_in;
   logic       pwm_on_ff, pwm_on_in;
   logic [7:0] pwm_value_ff, pwm_value_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   vss_pkg::rsp_item_type rsp_ff, rsp_in;

   logic       changed;
   logic [2:0] level_k;
   logic [7:0] tp, tm;
   logic [7:0] code;

   function automatic logic [vss_pkg::TIMER_W-1:0] reversal(
      input logic [vss_pkg::TICK_W-1:0]  full,
      input logic [vss_pkg::TIMER_W-1:0] other,
      input logic [vss_pkg::TICK_W-1:0]  guard
   );
      logic signed [17:0] v;
      logic [vss_pkg::TIMER_W-1:0] r;
      v = $signed({3'b000, full}) + $signed({3'b000, guard}) - $signed({2'b00, other});
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({3'b000, full})) begin
         r = {1'b0, full};
      end else begin
         r = v[vss_pkg::TIMER_W-1:0];
      end
      return r;
   endfunction

   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      stage_in     = stage_ff;
      goal_in      = goal_ff;
      goal_seen_in = goal_seen_ff;
      up_in        = up_ff;
      down_in      = down_ff;
      applied_in   = applied_ff;
      requested_in = requested_ff;
      auto_in      = auto_ff;
      pwm_on_in    = pwm_on_ff;
      pwm_value_in = pwm_value_ff;
      changed      = 1'b0;
      level_k      = (requested_ff > LEVEL_MAX) ? LEVEL_MAX : requested_ff;

      if (q_pop && q_item.kind == vss_pkg::KIND_CMD) begin
         goal_seen_in = goal_ff;
         goal_in      = q_item.target_stage;
         requested_in = q_item.heater_level;
         auto_in      = q_item.heater_mode;
      end else if (q_pop) begin
         if (!auto_ff && applied_ff != requested_ff) begin
            if (level_k == 3'd0) begin
               pwm_on_in = 1'b0;
            end else begin
               pwm_on_in    = 1'b1;
               pwm_value_in = vss_pkg::duty_of(level_k);
            end
            applied_in = requested_ff;
            changed    = 1'b1;
         end
         if (up_ff != '0) begin
            up_in = up_ff - 1'b1;
            if (up_in == '0) changed = 1'b1;
         end
         if (down_ff != '0) begin
            down_in = down_ff - 1'b1;
            if (down_in == '0) changed = 1'b1;
         end
         if (goal_seen_ff != goal_ff) changed = 1'b1;
         goal_seen_in = goal_ff;

         if ({2'b00, stage_ff} < goal_ff) begin
            case (stage_ff)
               S1: begin
                  stage_in = S2;
                  up_in    = reversal(valve_open_ff, down_in, valve_guard_ff);
                  down_in  = '0;
               end
               S2: begin
                  if (up_in == '0) begin
                     stage_in = S3;
                     up_in    = {1'b0, motor_start_ff};
                     down_in  = '0;
                  end
               end
               S3: begin
                  if (up_in == '0) begin
                     stage_in = S4;
                     down_in  = '0;
                  end
               end
               default: begin
                  goal_in = {2'b00, stage_ff};
               end
            endcase
         end else if ({2'b00, stage_ff} > goal_ff) begin
            case (stage_ff)
               S4: begin
                  auto_in      = 1'b0;
                  requested_in = '0;
                  pwm_on_in    = 1'b0;
                  applied_in   = '0;
                  stage_in     = S3;
                  down_in      = {1'b0, heater_cool_ff};
                  up_in        = '0;
               end
               S3: begin
                  if (down_in == '0) stage_in = S2;
               end
               S2: begin
                  stage_in = S1;
                  down_in  = reversal(valve_close_ff, up_in, valve_guard_ff);
                  up_in    = '0;
               end
               default: begin
                  stage_in = stage_ff;
               end
            endcase
         end
         if (stage_in != stage_ff) changed = 1'b1;
      end

      tp = up_in[15:8];
      tm = down_in[15:8];
      if (tm > tp) begin
         code = tm + {7'b0, down_in != '0};
      end else begin
         code = tp + {7'b0, up_in != '0};
      end

      rsp_in.current_stage       = stage_in;
      rsp_in.target_stage        = goal_in;
      rsp_in.heater_level_now    = applied_in;
      rsp_in.heater_level_goal   = requested_in;
      rsp_in.heater_mode_now     = auto_in;
      rsp_in.remaining_time_code = code;
      rsp_in.pwm_enable          = pwm_on_in;
      rsp_in.pwm_duty            = pwm_value_in;

      if (q_pop && q_item.kind == vss_pkg::KIND_TICK && changed) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valve_open_ff  <= vss_pkg::VALVE_OPEN_RESET;
         valve_close_ff <= vss_pkg::VALVE_CLOSE_RESET;
         valve_guard_ff <= vss_pkg::VALVE_GUARD_RESET;
         motor_start_ff <= vss_pkg::MOTOR_START_RESET;
         heater_cool_ff <= vss_pkg::HEATER_COOL_RESET;
         stage_ff       <= S1;
         goal_ff        <= '0;
         goal_seen_ff   <= '0;
         up_ff          <= '0;
         down_ff        <= {1'b0, vss_pkg::VALVE_CLOSE_RESET};
         applied_ff     <= '0;
         requested_ff   <= '0;
         auto_ff        <= 1'b0;
         pwm_on_ff      <= 1'b0;
         pwm_value_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr.we) begin
            case (vss_pkg::cfg_index_type'(csr.index))
               vss_pkg::CFG_VALVE_OPEN:  valve_open_ff  <= csr.data;
               vss_pkg::CFG_VALVE_CLOSE: valve_close_ff <= csr.data;
               vss_pkg::CFG_VALVE_GUARD: valve_guard_ff <= csr.data;
               vss_pkg::CFG_MOTOR_START: motor_start_ff <= csr.data;
               vss_pkg::CFG_HEATER_COOL: heater_cool_ff <= csr.data;
               default: begin
               end
            endcase
         end
         stage_ff     <= stage_in;
         goal_ff      <= goal_in;
         goal_seen_ff <= goal_seen_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         applied_ff   <= applied_in;
         requested_ff <= requested_in;
         auto_ff      <= auto_in;
         pwm_on_ff    <= pwm_on_in;
         pwm_value_ff <= pwm_value_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_valid_in && !(rsp_valid_ff && !rsp.ready)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.current_stage       = rsp_ff.current_stage;
   assign rsp.target_stage        = rsp_ff.target_stage;
   assign rsp.heater_level_now    = rsp_ff.heater_level_now;
   assign rsp.heater_level_goal   = rsp_ff.heater_level_goal;
   assign rsp.heater_mode_now     = rsp_ff.heater_mode_now;
   assign rsp.remaining_time_code = rsp_ff.remaining_time_code;
   assign rsp.pwm_enable          = rsp_ff.pwm_enable;
   assign rsp.pwm_duty            = rsp_ff.pwm_duty;

   `VSS_ASSERT_HOLDS(a_single_step, clock, reset, stage_in != stage_ff, (stage_in == stage_ff + 2'd1) || (stage_in + 2'd1 == stage_ff), "stage moved by more than one")
   `VSS_ASSERT_HOLDS(a_timer_range, clock, reset, 1'b1, !up_ff[15] && !down_ff[15], "timer above full time")
   `VSS_ASSERT_NEXT(a_heater_off, clock, reset, stage_ff == S4 && stage_in == S3, !pwm_on_ff && applied_ff == '0, "heater left on after leaving heater stage")

endmodule

[dv/ventilation_stage_sequencer_core_tb.sv]
// Self-checking testbench for ventilation_stage_sequencer_core: directed stage walks, then
// random command and tick sequences under several register settings with random idling.
// Depends on vss_pkg, vss_if and the RTL of the sequencer core.
module ventilation_stage_sequencer_core_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_PERCENT  = 34;

   localparam logic [1:0] STAGE_VALVE_CLOSED = 2'd0;
   localparam logic [1:0] STAGE_VALVE_OPEN   = 2'd1;
   localparam logic [1:0] STAGE_MOTOR_ON     = 2'd2;
   localparam logic [1:0] STAGE_HEATER_ON    = 2'd3;

   localparam logic [7:0] HEATER_DUTY [8] = '{8'd0, 8'd24, 8'd31, 8'd40, 8'd51, 8'd92,
                                              8'd92, 8'd92};

   logic clock;
   logic reset;
   logic csr_we;
   logic [vss_pkg::CSR_IDX_W-1:0] csr_index;
   logic [vss_pkg::TICK_W-1:0] csr_wdata;

   vss_req_if req ();
   vss_rsp_if rsp ();

   ventilation_stage_sequencer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted register settings and sequencer state.
   logic [vss_pkg::TICK_W-1:0] open_ticks, close_ticks, guard_ticks, motor_ticks, cool_ticks;
   logic [1:0] stage_now;
   logic [3:0] stage_goal, stage_goal_seen;
   logic [vss_pkg::TIMER_W-1:0] up_count, down_count;
   logic [2:0] heat_applied, heat_requested;
   logic heat_auto, pwm_on;
   logic [7:0] pwm_duty;

   vss_pkg::rsp_item_type status_expected [$];
   vss_pkg::rsp_item_type status_want;

   bit sender_idles;
   bit receiver_idles;
   int mismatches;
   int beats_sent;
   int status_checked;
   int settings_used;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("ventilation_stage_sequencer_core regression: fail");
      $finish;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("status beat %0d field %s: got %0d, expected %0d",
                                   status_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (status_expected.size() == 0) begin
            report_mismatch($sformatf("status beat %0d arrived with none pending",
                                      status_checked));
         end else begin
            status_want = status_expected.pop_front();
            check_field("current_stage", rsp.current_stage, status_want.current_stage);
            check_field("target_stage", rsp.target_stage, status_want.target_stage);
            check_field("heater_level_now", rsp.heater_level_now,
                        status_want.heater_level_now);
            check_field("heater_level_goal", rsp.heater_level_goal,
                        status_want.heater_level_goal);
            check_field("heater_mode_now", rsp.heater_mode_now, status_want.heater_mode_now);
            check_field("remaining_time_code", rsp.remaining_time_code,
                        status_want.remaining_time_code);
            check_field("pwm_enable", rsp.pwm_enable, status_want.pwm_enable);
            check_field("pwm_duty", rsp.pwm_duty, status_want.pwm_duty);
         end
         status_checked++;
      end
   end

   function automatic logic [vss_pkg::TIMER_W-1:0] reversal_ticks(
      input logic [vss_pkg::TICK_W-1:0] full,
      input logic [vss_pkg::TIMER_W-1:0] other
   );
      int span;
      span = int'(full) - int'(other) + int'(guard_ticks);
      if (span < 0) span = 0;
      if (span > int'(full)) span = int'(full);
      return span[vss_pkg::TIMER_W-1:0];
   endfunction

   task automatic apply_heater(input logic [2:0] level);
      int slot;
      slot = level;
      if (slot >= vss_pkg::HEATER_LEVELS) slot = vss_pkg::HEATER_LEVELS - 1;
      if (slot == 0) begin
         pwm_on = 1'b0;
      end else begin
         pwm_on = 1'b1;
         pwm_duty = HEATER_DUTY[slot];
      end
   endtask

   task automatic climb_stage();
      case (stage_now)
         STAGE_VALVE_CLOSED: begin
            stage_now = STAGE_VALVE_OPEN;
            up_count = reversal_ticks(open_ticks, down_count);
            down_count = '0;
         end
         STAGE_VALVE_OPEN: begin
            if (up_count == 0) begin
               stage_now = STAGE_MOTOR_ON;
               up_count = {1'b0, motor_ticks};
               down_count = '0;
            end
         end
         STAGE_MOTOR_ON: begin
            if (up_count == 0) begin
               stage_now = STAGE_HEATER_ON;
               down_count = '0;
            end
         end
         default: begin
            stage_goal = {2'b00, stage_now};
         end
      endcase
   endtask

   task automatic descend_stage();
      case (stage_now)
         STAGE_HEATER_ON: begin
            heat_auto = 1'b0;
            heat_requested = 3'd0;
            apply_heater(3'd0);
            heat_applied = 3'd0;
            stage_now = STAGE_MOTOR_ON;
            down_count = {1'b0, cool_ticks};
            up_count = '0;
         end
         STAGE_MOTOR_ON: begin
            if (down_count == 0) stage_now = STAGE_VALVE_OPEN;
         end
         STAGE_VALVE_OPEN: begin
            stage_now = STAGE_VALVE_CLOSED;
            down_count = reversal_ticks(close_ticks, up_count);
            up_count = '0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic advance_sequencer(input vss_pkg::item_kind_type kind,
                                    input logic [3:0] target,
                                    input logic [2:0] level, input logic mode);
      bit changed;
      logic [1:0] stage_was;
      logic [7:0] up_high, down_high, code;
      vss_pkg::rsp_item_type status;
      if (kind == vss_pkg::KIND_CMD) begin
         stage_goal_seen = stage_goal;
         stage_goal = target;
         heat_requested = level;
         heat_auto = mode;
      end else begin
         changed = 1'b0;
         if (!heat_auto && heat_applied != heat_requested) begin
            apply_heater(heat_requested);
            heat_applied = heat_requested;
            changed = 1'b1;
         end
         if (up_count != 0) begin
            up_count = up_count - 1'b1;
            if (up_count == 0) changed = 1'b1;
         end
         if (down_count != 0) begin
            down_count = down_count - 1'b1;
            if (down_count == 0) changed = 1'b1;
         end
         if (stage_goal_seen != stage_goal) changed = 1'b1;
         stage_goal_seen = stage_goal;
         if ({2'b00, stage_now} != stage_goal) begin
            stage_was = stage_now;
            if ({2'b00, stage_now} < stage_goal) climb_stage();
            else descend_stage();
            if (stage_was != stage_now) changed = 1'b1;
         end
         if (changed) begin
            up_high = up_count[15:8];
            down_high = down_count[15:8];
            if (down_high > up_high) code = down_high + {7'd0, down_count != 0};
            else code = up_high + {7'd0, up_count != 0};
            status.current_stage = stage_now;
            status.target_stage = stage_goal;
            status.heater_level_now = heat_applied;
            status.heater_level_goal = heat_requested;
            status.heater_mode_now = heat_auto;
            status.remaining_time_code = code;
            status.pwm_enable = pwm_on;
            status.pwm_duty = pwm_duty;
            status_expected.push_back(status);
         end
      end
   endtask

   task automatic send_item(input vss_pkg::item_kind_type kind, input logic [3:0] target,
                            input logic [2:0] level, input logic mode);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.req_type <= kind;
      req.cmd_target_stage <= target;
      req.cmd_heater_level <= level;
      req.cmd_heater_mode <= mode;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      advance_sequencer(kind, target, level, mode);
      beats_sent++;
   endtask

   task automatic send_tick();
      send_item(vss_pkg::KIND_TICK, 4'($urandom), 3'($urandom), 1'($urandom));
   endtask

   // Holds the request side quiet until every predicted status beat is back or the drain limit runs out.
   task automatic drain_status();
      int waited;
      waited = 0;
      @(negedge clock);
      req.valid <= 1'b0;
      while (status_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (status_expected.size() != 0) begin
         report_mismatch($sformatf("%0d status beats never arrived", status_expected.size()));
         status_expected.delete();
      end
   endtask

   task automatic write_reg(input vss_pkg::cfg_index_type index,
                            input logic [vss_pkg::TICK_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         vss_pkg::CFG_VALVE_OPEN:  open_ticks = value;
         vss_pkg::CFG_VALVE_CLOSE: close_ticks = value;
         vss_pkg::CFG_VALVE_GUARD: guard_ticks = value;
         vss_pkg::CFG_MOTOR_START: motor_ticks = value;
         vss_pkg::CFG_HEATER_COOL: cool_ticks = value;
         default: begin
         end
      endcase
   endtask

   task automatic load_settings(input logic [vss_pkg::TICK_W-1:0] open_v,
                                input logic [vss_pkg::TICK_W-1:0] close_v,
                                input logic [vss_pkg::TICK_W-1:0] guard_v,
                                input logic [vss_pkg::TICK_W-1:0] motor_v,
                                input logic [vss_pkg::TICK_W-1:0] cool_v);
      drain_status();
      write_reg(vss_pkg::CFG_VALVE_OPEN, open_v);
      write_reg(vss_pkg::CFG_VALVE_CLOSE, close_v);
      write_reg(vss_pkg::CFG_VALVE_GUARD, guard_v);
      write_reg(vss_pkg::CFG_MOTOR_START, motor_v);
      write_reg(vss_pkg::CFG_HEATER_COOL, cool_v);
      settings_used++;
   endtask

   // Mostly a command followed by a run of ticks, with stray single beats mixed in.
   task automatic run_sequences(input int count);
      int sent;
      int run_len;
      logic [3:0] target;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 80) begin
            target = ($urandom_range(99) < 85) ? 4'($urandom_range(3))
                                                : 4'($urandom_range(15, 4));
            send_item(vss_pkg::KIND_CMD, target, 3'($urandom),
                      ($urandom_range(99) < 75) ? 1'b0 : 1'b1);
            run_len = ($urandom_range(99) < 80) ? $urandom_range(1, 20)
                                                 : $urandom_range(21, 60);
            repeat (run_len) send_tick();
            sent += run_len + 1;
         end else begin
            send_item(vss_pkg::item_kind_type'($urandom_range(1)), 4'($urandom),
                      3'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_stage_walk();
      load_settings(15'd3, 15'd3, 15'd1, 15'd2, 15'd4);
      send_item(vss_pkg::KIND_CMD, 4'd15, 3'd7, 1'b0);
      repeat (6) send_tick();
      send_item(vss_pkg::KIND_CMD, 4'd3, 3'd0, 1'b0);
      send_tick();
      send_item(vss_pkg::KIND_CMD, 4'd3, 3'd4, 1'b1);
      send_tick();
      send_item(vss_pkg::KIND_CMD, 4'd0, 3'd3, 1'b0);
      repeat (6) send_tick();
      send_item(vss_pkg::KIND_CMD, 4'd1, 3'd1, 1'b0);
      send_tick();
      send_item(vss_pkg::KIND_CMD, 4'd0, 3'd2, 1'b0);
      send_tick();
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      load_settings(15'($urandom_range(8)), 15'($urandom_range(8)), 15'($urandom_range(8)),
                    15'($urandom_range(8)), 15'($urandom_range(8)));
      run_sequences(200);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_random_settings();
      repeat (5) begin
         load_settings(15'($urandom_range(8)), 15'($urandom_range(8)),
                       15'($urandom_range(8)), 15'($urandom_range(8)),
                       15'($urandom_range(8)));
         run_sequences(110);
      end
   endtask

   task automatic test_zero_settings();
      load_settings(15'd0, 15'd0, 15'd0, 15'd0, 15'd0);
      run_sequences(100);
   endtask

   task automatic test_guard_saturation();
      load_settings(15'($urandom_range(1, 6)), 15'($urandom_range(1, 6)), 15'h7FFF,
                    15'($urandom_range(4)), 15'($urandom_range(4)));
      run_sequences(100);
   endtask

   // Full-scale timers never run out within this phase, so it goes last.
   task automatic test_max_settings();
      load_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      run_sequences(50);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.req_type = vss_pkg::KIND_TICK;
      req.cmd_target_stage = '0;
      req.cmd_heater_level = '0;
      req.cmd_heater_mode = 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      mismatches = 0;
      beats_sent = 0;
      status_checked = 0;
      settings_used = 0;
      open_ticks = vss_pkg::VALVE_OPEN_RESET;
      close_ticks = vss_pkg::VALVE_CLOSE_RESET;
      guard_ticks = vss_pkg::VALVE_GUARD_RESET;
      motor_ticks = vss_pkg::MOTOR_START_RESET;
      cool_ticks = vss_pkg::HEATER_COOL_RESET;
      stage_now = STAGE_VALVE_CLOSED;
      stage_goal = 4'd0;
      stage_goal_seen = 4'd0;
      up_count = '0;
      down_count = {1'b0, vss_pkg::VALVE_CLOSE_RESET};
      heat_applied = 3'd0;
      heat_requested = 3'd0;
      heat_auto = 1'b0;
      pwm_on = 1'b0;
      pwm_duty = 8'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_stage_walk();
      test_steady_stream();
      test_random_settings();
      test_zero_settings();
      test_guard_saturation();
      test_max_settings();
      drain_status();

      $display("Sent %0d request beats and checked %0d status beats", beats_sent,
               status_checked);
      $display("across %0d register settings, from all zero to full scale.", settings_used);
      if (mismatches == 0) begin
         $display("ventilation_stage_sequencer_core regression: pass");
      end else begin
         $display("ventilation_stage_sequencer_core regression: fail");
      end
      $finish;
   end

endmodule
